@@ hw/rtl/altu_pkg.sv @@
// altu_pkg: shared types, codes and character class helpers for the line tokenizer.
// Used by altu_front, altu_back, altu_outq and assembler_line_tokenizer_unit.
`timescale 1ns / 1ps
`default_nettype none
package altu_pkg;

    localparam logic [2:0] K_SYM = 3'd0;
    localparam logic [2:0] K_CMD = 3'd1;
    localparam logic [2:0] K_STR = 3'd2;
    localparam logic [2:0] K_NUM = 3'd3;
    localparam logic [2:0] K_ONE = 3'd4;

    localparam int unsigned QDEPTH = 4;

    typedef struct packed {
        logic alpha;
        logic digit;
        logic xdigit;
        logic bdigit;
        logic odigit;
        logic space;
    } t_cls;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] token_kind;
        logic       token_first;
        logic       token_last;
        logic       empty_token;
        logic       line_end;
        logic [7:0] token_count;
    } t_res;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r.alpha  = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
        r.digit  = (c >= 8'h30 && c <= 8'h39);
        r.xdigit = r.digit || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
        r.bdigit = (c == 8'h30) || (c == 8'h31);
        r.odigit = (c >= 8'h30 && c <= 8'h37);
        r.space  = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/assembler_line_tokenizer_unit.sv @@
// assembler_line_tokenizer_unit: top level; input queue, lexer engine, result queue.
// Depends on altu_pkg, altu_front, altu_back, altu_outq.
//
//  channel   | handshake        | payload
//  ----------+------------------+------------------------------------------------
//  text in   | push / full      | i_text_byte
//  tokens out| empty / pop      | o_out_byte, o_token_kind, o_token_first,
//            |                  | o_token_last, o_empty_token, o_line_end,
//            |                  | o_token_count
//  config    | i_cfg_we         | i_cfg_wdata (token limit)
//
// One item per cycle while the engine keeps up; it takes one step a cycle and emits at
// most one result per step. Some steps take no byte: the end of a symbol, command or
// number, entering the skip state, the end of a hex or octal escape or of a bare \x,
// and a string or escape cut off by the line end.
// Reset is synchronous, active low; the token limit returns to 64.
// The input queue holds four bytes and the engine waits there for lookahead; it stalls
// while the result queue is full.
`timescale 1ns / 1ps
`default_nettype none
module assembler_line_tokenizer_unit #(
    parameter int unsigned OUT_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_text_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_token_kind,
    output logic             o_token_first,
    output logic             o_token_last,
    output logic             o_empty_token,
    output logic             o_line_end,
    output logic [7:0]       o_token_count,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);
    logic [2:0]           w_cnt;
    logic [3:0][7:0]      w_bytes;
    altu_pkg::t_cls [3:0] w_cls;
    logic                 w_pop, w_emit, w_ofull;
    altu_pkg::t_res       w_res, w_head;

    altu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_text_byte (i_text_byte),
        .i_pop       (w_pop),
        .o_cnt       (w_cnt),
        .o_bytes     (w_bytes),
        .o_cls       (w_cls)
    );

    altu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cnt       (w_cnt),
        .i_bytes     (w_bytes),
        .i_cls       (w_cls),
        .o_pop       (w_pop),
        .i_out_full  (w_ofull),
        .o_emit      (w_emit),
        .o_res       (w_res)
    );

    altu_outq #(.DEPTH(OUT_DEPTH)) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit),
        .i_res   (w_res),
        .o_full  (w_ofull),
        .pop     (pop),
        .empty   (empty),
        .o_res   (w_head)
    );

    assign o_out_byte    = w_head.out_byte;
    assign o_token_kind  = w_head.token_kind;
    assign o_token_first = w_head.token_first;
    assign o_token_last  = w_head.token_last;
    assign o_empty_token = w_head.empty_token;
    assign o_line_end    = w_head.line_end;
    assign o_token_count = w_head.token_count;
endmodule
`default_nettype wire

@@ hw/rtl/altu_front.sv @@
// altu_front: input byte queue; classifies each item on entry.
// Depends on altu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module altu_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic                 i_pop,
    output logic [2:0]                o_cnt,
    output logic [3:0][7:0]           o_bytes,
    output altu_pkg::t_cls [3:0]      o_cls
);
    logic [2:0]              r_cnt, n_cnt;
    logic [3:0][7:0]         r_bytes, n_bytes;
    altu_pkg::t_cls [3:0]    r_cls, n_cls;
    logic                    w_push;
    logic [2:0]              w_wpos;
    altu_pkg::t_cls          w_cls;

    assign full    = (r_cnt == 3'(altu_pkg::QDEPTH));
    assign w_push  = push && !full;
    assign w_cls   = altu_pkg::classify(i_text_byte);
    assign w_wpos  = r_cnt - {2'b00, i_pop};
    assign o_cnt   = r_cnt;
    assign o_bytes = r_bytes;
    assign o_cls   = r_cls;

    always_comb begin
        n_bytes = r_bytes;
        n_cls   = r_cls;
        if (i_pop) begin
            for (int k = 0; k < 3; k++) begin
                n_bytes[k] = r_bytes[k+1];
                n_cls[k]   = r_cls[k+1];
            end
        end
        if (w_push) begin
            n_bytes[w_wpos[1:0]] = i_text_byte;
            n_cls[w_wpos[1:0]]   = w_cls;
        end
        n_cnt = r_cnt - {2'b00, i_pop} + {2'b00, w_push};
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_cls   <= n_cls;
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/altu_outq.sv @@
// altu_outq: result item queue between the lexer and the result ports.
// Depends on altu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module altu_outq #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire altu_pkg::t_res  i_res,
    output logic                 o_full,
    input  wire logic            pop,
    output logic                 empty,
    output altu_pkg::t_res       o_res
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    altu_pkg::t_res   r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_pop;

    assign empty  = (r_cnt == '0);
    assign o_full = (r_cnt == CW'(DEPTH));
    assign w_pop  = pop && !empty;
    assign o_res  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(w_pop);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/altu_back.sv @@
// altu_back: lexer engine; one step a cycle unless stalled, one result at most.
// Depends on altu_pkg; fed by altu_front, feeds altu_outq.
`timescale 1ns / 1ps
`default_nettype none
module altu_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [7:0]           i_cfg_wdata,
    input  wire logic [2:0]           i_cnt,
    input  wire logic [3:0][7:0]      i_bytes,
    input  wire altu_pkg::t_cls [3:0] i_cls,
    output logic                      o_pop,
    input  wire logic                 i_out_full,
    output logic                      o_emit,
    output altu_pkg::t_res            o_res
);
    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_SKIP = 4'd1;
    localparam logic [3:0] M_SYM  = 4'd2;
    localparam logic [3:0] M_CMD  = 4'd3;
    localparam logic [3:0] M_DEC  = 4'd4;
    localparam logic [3:0] M_HEX  = 4'd5;
    localparam logic [3:0] M_BIN  = 4'd6;
    localparam logic [3:0] M_STR  = 4'd7;
    localparam logic [3:0] M_ESC  = 4'd8;
    localparam logic [3:0] M_XST  = 4'd9;
    localparam logic [3:0] M_XHEX = 4'd10;
    localparam logic [3:0] M_OCT  = 4'd11;
    localparam logic [3:0] M_PRE  = 4'd12;

    logic [7:0] r_limit;
    logic [3:0] r_mode, n_mode, r_pmode, n_pmode;
    logic [7:0] r_tok, n_tok, r_esc, n_esc, r_pb, n_pb;
    logic       r_pv, n_pv, r_nf, n_nf;
    logic [2:0] r_kind, n_kind;
    logic [1:0] r_pre, n_pre;

    logic [3:0]           w_endb, w_pres;
    logic [3:0][7:0]      w_v;
    altu_pkg::t_cls [3:0] w_c;
    logic                 w_go, w_cont, w_wait, w_start, w_one;
    logic [2:0]           w_m, w_skind;
    logic [3:0]           w_smode;
    logic [7:0]           c0;

    always_comb begin
        w_endb[0] = 1'b0;
        for (int k = 1; k < 4; k++) begin
            w_endb[k] = w_endb[k-1] || ((3'(k - 1) < i_cnt) && (i_bytes[k-1] == 8'd0));
        end
        for (int k = 0; k < 4; k++) begin
            w_pres[k] = (3'(k) < i_cnt) || w_endb[k];
            w_v[k]    = w_endb[k] ? 8'd0 : i_bytes[k];
            w_c[k]    = w_endb[k] ? '0 : i_cls[k];
        end
    end

    assign c0   = w_v[0];
    assign w_go = (i_cnt != 3'd0) && !i_out_full;

    always_comb begin
        unique case (r_mode)
            M_SYM:   w_cont = w_c[0].alpha || w_c[0].digit || c0 == 8'h5f || c0 == 8'h2e;
            M_CMD:   w_cont = w_c[0].alpha || w_c[0].digit || c0 == 8'h5f;
            M_DEC:   w_cont = w_c[0].digit;
            M_HEX:   w_cont = w_c[0].xdigit;
            default: w_cont = w_c[0].bdigit;
        endcase
    end

    // token start decision from the idle state
    always_comb begin
        w_wait  = 1'b0;
        w_start = 1'b0;
        w_one   = 1'b0;
        w_m     = 3'd1;
        w_skind = altu_pkg::K_ONE;
        w_smode = M_IDLE;
        if (c0 == 8'h2f) begin
            if (!w_pres[1]) begin
                w_wait = 1'b1;
            end else begin
                w_one = (w_v[1] != 8'h2f);
            end
        end else if (w_c[0].alpha || c0 == 8'h5f) begin
            w_start = 1'b1;
            w_skind = altu_pkg::K_SYM;
            w_smode = M_SYM;
        end else if (c0 == 8'h2e) begin
            if (!w_pres[1]) begin
                w_wait = 1'b1;
            end else if (w_c[1].alpha) begin
                w_start = 1'b1;
                w_skind = altu_pkg::K_CMD;
                w_smode = M_CMD;
            end else begin
                w_one = 1'b1;
            end
        end else if (c0 == 8'h2b || c0 == 8'h2d) begin
            if (!w_pres[1]) begin
                w_wait = 1'b1;
            end else if (w_v[1] == 8'h30 && !w_pres[2]) begin
                w_wait = 1'b1;
            end else if (w_v[1] == 8'h30 && (w_v[2] == 8'h78 || w_v[2] == 8'h62)
                         && !w_pres[3]) begin
                w_wait = 1'b1;
            end else if (w_v[1] == 8'h30 && w_v[2] == 8'h78 && w_c[3].xdigit) begin
                w_start = 1'b1;
                w_m     = 3'd4;
                w_skind = altu_pkg::K_NUM;
                w_smode = M_HEX;
            end else if (w_v[1] == 8'h30 && w_v[2] == 8'h62 && w_c[3].bdigit) begin
                w_start = 1'b1;
                w_m     = 3'd4;
                w_skind = altu_pkg::K_NUM;
                w_smode = M_BIN;
            end else if (w_c[1].digit) begin
                w_start = 1'b1;
                w_skind = altu_pkg::K_NUM;
                w_smode = M_DEC;
            end else begin
                w_one = 1'b1;
            end
        end else if (c0 == 8'h30) begin
            w_skind = altu_pkg::K_NUM;
            w_smode = M_DEC;
            if (!w_pres[1]) begin
                w_wait = 1'b1;
            end else if ((w_v[1] == 8'h78 || w_v[1] == 8'h62) && !w_pres[2]) begin
                w_wait = 1'b1;
            end else begin
                w_start = 1'b1;
                if (w_v[1] == 8'h78 && w_c[2].xdigit) begin
                    w_m     = 3'd3;
                    w_smode = M_HEX;
                end else if (w_v[1] == 8'h62 && w_c[2].bdigit) begin
                    w_m     = 3'd3;
                    w_smode = M_BIN;
                end
            end
        end else if (w_c[0].digit) begin
            w_start = 1'b1;
            w_skind = altu_pkg::K_NUM;
            w_smode = M_DEC;
        end else begin
            w_one = 1'b1;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_pmode = r_pmode;
        n_tok   = r_tok;
        n_esc   = r_esc;
        n_pb    = r_pb;
        n_pv    = r_pv;
        n_nf    = r_nf;
        n_kind  = r_kind;
        n_pre   = r_pre;
        o_pop   = 1'b0;
        o_emit  = 1'b0;
        o_res   = '0;
        if (w_go) begin
            unique case (r_mode)
                M_IDLE, M_SKIP: begin
                    if (c0 == 8'd0) begin
                        o_emit            = 1'b1;
                        o_res.line_end    = 1'b1;
                        o_res.token_count = r_tok;
                        o_pop             = 1'b1;
                        n_mode            = M_IDLE;
                        n_tok             = 8'd0;
                        n_esc             = 8'd0;
                        n_pv              = 1'b0;
                        n_nf              = 1'b0;
                        n_kind            = altu_pkg::K_SYM;
                    end else if (r_mode == M_SKIP) begin
                        o_pop = 1'b1;
                    end else if (r_tok >= r_limit) begin
                        n_mode = M_SKIP;
                    end else if (w_c[0].space) begin
                        o_pop = 1'b1;
                    end else if (c0 == 8'h23 || c0 == 8'h3b) begin
                        n_mode = M_SKIP;
                    end else if (c0 == 8'h22) begin
                        o_pop  = 1'b1;
                        n_tok  = r_tok + 8'd1;
                        n_kind = altu_pkg::K_STR;
                        n_nf   = 1'b1;
                        n_pv   = 1'b0;
                        n_mode = M_STR;
                    end else if (w_wait) begin
                        n_mode = M_IDLE;
                    end else if (w_one) begin
                        o_emit            = 1'b1;
                        o_res.out_byte    = c0;
                        o_res.token_kind  = altu_pkg::K_ONE;
                        o_res.token_first = 1'b1;
                        o_res.token_last  = 1'b1;
                        o_pop             = 1'b1;
                        n_tok             = r_tok + 8'd1;
                    end else if (w_start) begin
                        // hold a lone first byte; a 0x/0b prefix goes out byte by byte
                        o_pop  = 1'b1;
                        n_tok  = r_tok + 8'd1;
                        n_kind = w_skind;
                        if (w_m == 3'd1) begin
                            n_nf   = 1'b1;
                            n_pb   = c0;
                            n_pv   = 1'b1;
                            n_mode = w_smode;
                        end else begin
                            o_emit            = 1'b1;
                            o_res.out_byte    = c0;
                            o_res.token_kind  = w_skind;
                            o_res.token_first = 1'b1;
                            n_nf              = 1'b0;
                            n_pre             = 2'(w_m - 3'd1);
                            n_pmode           = w_smode;
                            n_mode            = M_PRE;
                        end
                    end else begin
                        // comment start "//"
                        n_mode = M_SKIP;
                    end
                end
                M_PRE: begin
                    o_pop = 1'b1;
                    if (r_pre == 2'd1) begin
                        n_pb   = c0;
                        n_pv   = 1'b1;
                        n_mode = r_pmode;
                        n_pre  = 2'd0;
                    end else begin
                        o_emit           = 1'b1;
                        o_res.out_byte   = c0;
                        o_res.token_kind = r_kind;
                        n_pre            = r_pre - 2'd1;
                    end
                end
                M_SYM, M_CMD, M_DEC, M_HEX, M_BIN: begin
                    o_emit            = r_pv;
                    o_res.out_byte    = r_pb;
                    o_res.token_kind  = r_kind;
                    o_res.token_first = r_nf;
                    if (r_pv) begin
                        n_nf = 1'b0;
                    end
                    if (c0 != 8'd0 && w_cont) begin
                        n_pb  = c0;
                        n_pv  = 1'b1;
                        o_pop = 1'b1;
                    end else begin
                        o_res.token_last = 1'b1;
                        n_pv             = 1'b0;
                        n_mode           = M_IDLE;
                    end
                end
                M_STR: begin
                    o_res.out_byte    = r_pb;
                    o_res.token_kind  = altu_pkg::K_STR;
                    o_res.token_first = r_nf;
                    if (c0 == 8'h22 || c0 == 8'd0) begin
                        o_emit            = r_pv || r_nf;
                        o_res.token_last  = 1'b1;
                        o_res.empty_token = !r_pv;
                        if (!r_pv) begin
                            o_res.out_byte = 8'd0;
                        end
                        n_nf   = 1'b0;
                        n_pv   = 1'b0;
                        n_mode = M_IDLE;
                        o_pop  = (c0 == 8'h22);
                    end else begin
                        o_emit = r_pv;
                        if (r_pv) begin
                            n_nf = 1'b0;
                        end
                        o_pop = 1'b1;
                        if (c0 == 8'h5c) begin
                            n_pv   = 1'b0;
                            n_mode = M_ESC;
                        end else begin
                            n_pb = c0;
                            n_pv = 1'b1;
                        end
                    end
                end
                M_ESC: begin
                    n_mode = M_STR;
                    n_pv   = 1'b1;
                    n_pb   = c0;
                    o_pop  = (c0 != 8'd0);
                    unique case (c0)
                        8'h61:   n_pb = 8'd7;
                        8'h62:   n_pb = 8'd8;
                        8'h66:   n_pb = 8'd12;
                        8'h6e:   n_pb = 8'd10;
                        8'h72:   n_pb = 8'd13;
                        8'h74:   n_pb = 8'd9;
                        8'h76:   n_pb = 8'd11;
                        8'h78: begin
                            n_pv   = 1'b0;
                            n_mode = M_XST;
                        end
                        default: begin
                            if (w_c[0].odigit) begin
                                n_pv   = 1'b0;
                                n_esc  = {5'd0, c0[2:0]};
                                n_mode = M_OCT;
                            end
                        end
                    endcase
                end
                M_XST: begin
                    if (w_c[0].xdigit) begin
                        n_esc  = {4'd0, altu_pkg::hex_val(c0)};
                        n_mode = M_XHEX;
                        o_pop  = 1'b1;
                    end else begin
                        n_pb   = 8'h78;
                        n_pv   = 1'b1;
                        n_mode = M_STR;
                    end
                end
                M_XHEX, M_OCT: begin
                    if (r_mode == M_XHEX && w_c[0].xdigit) begin
                        n_esc = {r_esc[3:0], altu_pkg::hex_val(c0)};
                        o_pop = 1'b1;
                    end else if (r_mode == M_OCT && w_c[0].odigit) begin
                        n_esc = {r_esc[4:0], c0[2:0]};
                        o_pop = 1'b1;
                    end else begin
                        n_pb   = r_esc;
                        n_pv   = 1'b1;
                        n_mode = M_STR;
                    end
                end
                default: n_mode = M_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 8'd64;
            r_mode  <= M_IDLE;
            r_pmode <= M_IDLE;
            r_tok   <= 8'd0;
            r_esc   <= 8'd0;
            r_pb    <= 8'd0;
            r_pv    <= 1'b0;
            r_nf    <= 1'b0;
            r_kind  <= altu_pkg::K_SYM;
            r_pre   <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_mode  <= n_mode;
            r_pmode <= n_pmode;
            r_tok   <= n_tok;
            r_esc   <= n_esc;
            r_pb    <= n_pb;
            r_pv    <= n_pv;
            r_nf    <= n_nf;
            r_kind  <= n_kind;
            r_pre   <= n_pre;
        end
    end
endmodule
`default_nettype wire

@@ tb/sv/assembler_line_tokenizer_unit_tb.sv @@
// Self-checking testbench for assembler_line_tokenizer_unit: source lines in, token bytes out.
// Depends on altu_pkg and the RTL; a built-in lexer predictor checks every result item.
`timescale 1ns / 1ps
module assembler_line_tokenizer_unit_tb;

    typedef enum logic [3:0] {
        S_IDLE, S_SKIP, S_SYM, S_CMD, S_DEC, S_HEX, S_BIN,
        S_STR, S_ESC, S_XSTART, S_XHEX, S_OCT
    } t_lex_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] i_text_byte = 8'd0;
    logic       pop = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;
    logic       full, empty;
    logic [7:0] o_out_byte, o_token_count;
    logic [2:0] o_token_kind;
    logic       o_token_first, o_token_last, o_empty_token, o_line_end;

    assembler_line_tokenizer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_text_byte(i_text_byte),
        .empty(empty), .pop(pop),
        .o_out_byte(o_out_byte), .o_token_kind(o_token_kind),
        .o_token_first(o_token_first), .o_token_last(o_token_last),
        .o_empty_token(o_empty_token), .o_line_end(o_line_end),
        .o_token_count(o_token_count),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // lexer state mirror
    logic [7:0] tok_limit = 8'd64;
    t_lex_mode  lx_mode = S_IDLE;
    logic [7:0] la_buf [3];
    int         la_n = 0;
    logic [7:0] tok_n = 8'd0;
    logic [7:0] esc_val = 8'd0;
    logic [7:0] held_byte = 8'd0;
    bit         held_v = 1'b0;
    bit         need_first = 1'b0;
    logic [2:0] cur_kind = 3'd0;
    int         step_n;

    altu_pkg::t_res token_q [$];
    logic [7:0] text_q [$];
    int         fails = 0;
    bit         calm = 1'b0;
    int         send_gap = 0;
    int         recv_stall = 0;
    int         wait_draw;

    initial forever #10 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit c_alpha(int c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit c_digit(int c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit c_xdigit(int c);
        return c_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction
    function automatic bit c_bdigit(int c);
        return c == "0" || c == "1";
    endfunction
    function automatic bit c_odigit(int c);
        return c >= "0" && c <= "7";
    endfunction
    function automatic bit c_space(int c);
        return c == " " || (c >= 9 && c <= 13);
    endfunction
    function automatic int nibble(int c);
        if (c_digit(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return c - "A" + 10;
    endfunction
    function automatic bit runs_on(t_lex_mode md, int c);
        case (md)
            S_SYM: return c_alpha(c) || c_digit(c) || c == "_" || c == ".";
            S_CMD: return c_alpha(c) || c_digit(c) || c == "_";
            S_DEC: return c_digit(c);
            S_HEX: return c_xdigit(c);
            default: return c_bdigit(c);
        endcase
    endfunction
    function automatic int peek_at(logic [7:0] w [4], int n, int p, bit ended);
        if (p < n) return w[p];
        return ended ? 0 : -1;
    endfunction

    task automatic emit(logic [7:0] b, logic [2:0] k, bit f, bit l, bit e, bit le,
                        logic [7:0] cnt);
        altu_pkg::t_res r;
        if (step_n >= 6) return;
        r.out_byte = b; r.token_kind = k; r.token_first = f; r.token_last = l;
        r.empty_token = e; r.line_end = le; r.token_count = cnt;
        token_q.push_back(r);
        step_n++;
    endtask

    task automatic flush_held(bit l);
        if (!held_v) return;
        emit(held_byte, cur_kind, need_first, l, 1'b0, 1'b0, 8'd0);
        need_first = 1'b0;
        held_v = 1'b0;
    endtask

    task automatic hold_byte(logic [7:0] c);
        held_byte = c;
        held_v = 1'b1;
    endtask

    task automatic lex_byte(logic [7:0] b);
        logic [7:0] w [4];
        int n, p, i, m, c0, c1, c2, c3, lc;
        logic [2:0] k;
        t_lex_mode nm;
        logic [7:0] v;
        bit ended, hx;
        step_n = 0;
        n = 0;
        p = 0;
        ended = (b == 8'd0);
        for (i = 0; i < 4; i++) w[i] = 8'd0;
        for (i = 0; i < la_n; i++) begin
            w[n] = la_buf[i];
            n++;
        end
        if (!ended) begin
            w[n] = b;
            n++;
        end
        while (1) begin
            c0 = peek_at(w, n, p, ended);
            if (c0 < 0) break;
            if (lx_mode == S_SKIP) begin
                if (p < n) begin
                    p++;
                    continue;
                end
                break;
            end
            if (lx_mode == S_IDLE) begin
                m = 1; k = altu_pkg::K_ONE; nm = S_IDLE;
                if (c0 == 0) break;
                if (tok_n >= tok_limit) begin
                    lx_mode = S_SKIP;
                    continue;
                end
                if (c_space(c0)) begin
                    p++;
                    continue;
                end
                if (c0 == "#" || c0 == ";") begin
                    lx_mode = S_SKIP;
                    continue;
                end
                if (c0 == "/") begin
                    c1 = peek_at(w, n, p + 1, ended);
                    if (c1 < 0) break;
                    if (c1 == "/") begin
                        lx_mode = S_SKIP;
                        continue;
                    end
                end else if (c_alpha(c0) || c0 == "_") begin
                    k = altu_pkg::K_SYM; nm = S_SYM;
                end else if (c0 == ".") begin
                    c1 = peek_at(w, n, p + 1, ended);
                    if (c1 < 0) break;
                    if (c_alpha(c1)) begin
                        k = altu_pkg::K_CMD; nm = S_CMD;
                    end
                end else if (c0 == "\"") begin
                    p++;
                    tok_n++;
                    cur_kind = altu_pkg::K_STR;
                    need_first = 1'b1;
                    held_v = 1'b0;
                    lx_mode = S_STR;
                    continue;
                end else if (c0 == "+" || c0 == "-") begin
                    c1 = peek_at(w, n, p + 1, ended);
                    if (c1 < 0) break;
                    if (c1 == "0") begin
                        c2 = peek_at(w, n, p + 2, ended);
                        if (c2 < 0) break;
                        if (c2 == "x" || c2 == "b") begin
                            c3 = peek_at(w, n, p + 3, ended);
                            if (c3 < 0) break;
                            if (c2 == "x" ? c_xdigit(c3) : c_bdigit(c3)) begin
                                m = 4; k = altu_pkg::K_NUM;
                                nm = (c2 == "x") ? S_HEX : S_BIN;
                            end
                        end
                    end
                    if (m == 1 && c_digit(c1)) begin
                        k = altu_pkg::K_NUM; nm = S_DEC;
                    end
                end else if (c0 == "0") begin
                    c1 = peek_at(w, n, p + 1, ended);
                    if (c1 < 0) break;
                    if (c1 == "x" || c1 == "b") begin
                        c2 = peek_at(w, n, p + 2, ended);
                        if (c2 < 0) break;
                        if (c1 == "x" ? c_xdigit(c2) : c_bdigit(c2)) begin
                            m = 3; nm = (c1 == "x") ? S_HEX : S_BIN;
                        end
                    end
                    k = altu_pkg::K_NUM;
                    if (m == 1) nm = S_DEC;
                end else if (c_digit(c0)) begin
                    k = altu_pkg::K_NUM; nm = S_DEC;
                end
                tok_n++;
                if (k == altu_pkg::K_ONE) begin
                    emit(c0[7:0], altu_pkg::K_ONE, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0);
                    p++;
                    continue;
                end
                cur_kind = k;
                need_first = 1'b1;
                for (i = 0; i < m - 1; i++) begin
                    emit(w[p + i], cur_kind, need_first, 1'b0, 1'b0, 1'b0, 8'd0);
                    need_first = 1'b0;
                end
                hold_byte(w[p + m - 1]);
                p += m;
                lx_mode = nm;
                continue;
            end
            if (lx_mode <= S_BIN) begin
                if (c0 != 0 && runs_on(lx_mode, c0)) begin
                    flush_held(1'b0);
                    hold_byte(c0[7:0]);
                    p++;
                end else begin
                    flush_held(1'b1);
                    lx_mode = S_IDLE;
                end
                continue;
            end
            if (lx_mode == S_STR) begin
                if (c0 == "\"" || c0 == 0) begin
                    if (held_v) flush_held(1'b1);
                    else if (need_first)
                        emit(8'd0, altu_pkg::K_STR, 1'b1, 1'b1, 1'b1, 1'b0, 8'd0);
                    need_first = 1'b0;
                    lx_mode = S_IDLE;
                    if (c0 == "\"") p++;
                end else begin
                    flush_held(1'b0);
                    if (c0 == "\\") lx_mode = S_ESC;
                    else hold_byte(c0[7:0]);
                    p++;
                end
                continue;
            end
            if (lx_mode == S_ESC) begin
                v = c0[7:0];
                lx_mode = S_STR;
                if (c0 == 0) begin
                    hold_byte(8'd0);
                    continue;
                end
                p++;
                case (c0)
                    "a": v = 8'd7;
                    "b": v = 8'd8;
                    "f": v = 8'd12;
                    "n": v = 8'd10;
                    "r": v = 8'd13;
                    "t": v = 8'd9;
                    "v": v = 8'd11;
                    "x": lx_mode = S_XSTART;
                    default: begin
                        if (c_odigit(c0)) begin
                            esc_val = 8'(c0 - "0");
                            lx_mode = S_OCT;
                        end
                    end
                endcase
                if (lx_mode == S_STR) hold_byte(v);
                continue;
            end
            if (lx_mode == S_XSTART) begin
                if (c_xdigit(c0)) begin
                    esc_val = 8'(nibble(c0));
                    lx_mode = S_XHEX;
                    p++;
                end else begin
                    hold_byte("x");
                    lx_mode = S_STR;
                end
                continue;
            end
            if (lx_mode == S_XHEX || lx_mode == S_OCT) begin
                hx = (lx_mode == S_XHEX);
                if (hx ? c_xdigit(c0) : c_odigit(c0)) begin
                    esc_val = hx ? 8'((esc_val << 4) + nibble(c0))
                                 : 8'((esc_val << 3) + (c0 - "0"));
                    p++;
                end else begin
                    hold_byte(esc_val);
                    lx_mode = S_STR;
                end
                continue;
            end
            lx_mode = S_IDLE;
        end
        if (ended) begin
            emit(8'd0, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1, tok_n);
            lx_mode = S_IDLE; la_n = 0; tok_n = 8'd0; esc_val = 8'd0;
            held_byte = 8'd0; held_v = 1'b0; need_first = 1'b0; cur_kind = 3'd0;
        end else begin
            lc = n - p;
            if (lc > 3) lc = 3;
            if (lc < 0) lc = 0;
            for (i = 0; i < lc; i++) la_buf[i] = w[p + i];
            la_n = lc;
        end
    endtask

    function automatic int draw_wait();
        if (calm) return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                lex_byte(i_text_byte);
            end
            if (!push || !full) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    push <= 1'b0;
                end else if (text_q.size() > 0) begin
                    i_text_byte <= text_q.pop_front();
                    push <= 1'b1;
                    send_gap <= draw_wait();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop && !empty) begin
            if (token_q.size() == 0) begin
                $error("result item with nothing expected");
                fails++;
            end else begin
                altu_pkg::t_res e;
                e = token_q.pop_front();
                if (o_out_byte !== e.out_byte) begin
                    $error("out_byte exp %0h got %0h", e.out_byte, o_out_byte);
                    fails++;
                end
                if (o_token_kind !== e.token_kind) begin
                    $error("token_kind exp %0d got %0d", e.token_kind, o_token_kind);
                    fails++;
                end
                if (o_token_first !== e.token_first) begin
                    $error("token_first exp %0b got %0b", e.token_first, o_token_first);
                    fails++;
                end
                if (o_token_last !== e.token_last) begin
                    $error("token_last exp %0b got %0b", e.token_last, o_token_last);
                    fails++;
                end
                if (o_empty_token !== e.empty_token) begin
                    $error("empty_token exp %0b got %0b", e.empty_token, o_empty_token);
                    fails++;
                end
                if (o_line_end !== e.line_end) begin
                    $error("line_end exp %0b got %0b", e.line_end, o_line_end);
                    fails++;
                end
                if (o_token_count !== e.token_count) begin
                    $error("token_count exp %0d got %0d", e.token_count, o_token_count);
                    fails++;
                end
            end
            wait_draw = draw_wait();
            recv_stall <= wait_draw;
            pop <= (wait_draw == 0);
        end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            pop <= (recv_stall == 1);
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    function automatic byte pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic add_run(string set, int lo, int hi);
        int cnt;
        cnt = $urandom_range(lo, hi);
        for (int i = 0; i < cnt; i++) text_q.push_back(pick(set));
    endtask

    task automatic add_string_tok();
        int parts;
        parts = $urandom_range(0, 4);
        text_q.push_back("\"");
        for (int i = 0; i < parts; i++) begin
            case ($urandom_range(0, 6))
                0, 1: add_run("abz AZ09.,+#;/'", 1, 3);
                2: begin
                    text_q.push_back("\\");
                    text_q.push_back(pick("abfnrtv\\'\"?qz"));
                end
                3: begin
                    add_text("\\x");
                    add_run("0123456789abcdefABCDEF", 1, 4);
                end
                4: begin
                    add_text("\\x");
                    text_q.push_back(pick("gxz \""));
                end
                5: begin
                    text_q.push_back("\\");
                    add_run("01234567", 1, 4);
                end
                default: text_q.push_back(8'($urandom_range(1, 255)));
            endcase
        end
        if ($urandom_range(0, 5) != 0) text_q.push_back("\"");
    endtask

    task automatic add_line();
        int toks;
        toks = $urandom_range(0, 7);
        for (int t = 0; t < toks; t++) begin
            case ($urandom_range(0, 12))
                0, 1: begin
                    text_q.push_back(pick("abcxyzABXZ_"));
                    add_run("az09_.AZ", 0, 4);
                end
                2: begin
                    text_q.push_back(".");
                    text_q.push_back(pick("abwzAZ"));
                    add_run("az09_", 0, 3);
                end
                3: add_run("0123456789", 1, 4);
                4: begin
                    text_q.push_back(pick("+-"));
                    add_run("0123456789", 1, 3);
                end
                5: begin
                    if ($urandom_range(0, 1)) text_q.push_back(pick("+-"));
                    add_text("0x");
                    add_run("0123456789abcdefABCDEF", 1, 4);
                end
                6: begin
                    if ($urandom_range(0, 1)) text_q.push_back(pick("+-"));
                    add_text("0b");
                    add_run("01", 1, 5);
                end
                7: begin
                    if ($urandom_range(0, 1)) text_q.push_back(pick("+-"));
                    text_q.push_back("0");
                    text_q.push_back(pick("xb"));
                    text_q.push_back(pick("gz2 ,."));
                end
                8, 9: add_string_tok();
                10: text_q.push_back(pick("+-,()[]*/.:=@"));
                11: text_q.push_back(8'($urandom_range(1, 255)));
                default: begin
                    case ($urandom_range(0, 2))
                        0: add_text("//");
                        1: text_q.push_back("#");
                        default: text_q.push_back(";");
                    endcase
                    add_run("ab \"\\x1", 0, 4);
                end
            endcase
            if ($urandom_range(0, 3) != 0) text_q.push_back(pick(" \t \v\f\r\n"));
        end
        text_q.push_back(8'd0);
    endtask

    task automatic drain();
        while (text_q.size() > 0 || push || token_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        tok_limit = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [7:0] limits [5];
        int sent;
        limits = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd64};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines under the reset limit
        add_text("_a.1 .d9 0xF -0b1 +7 0xg 0b2 . +");
        text_q.push_back(8'd0);
        add_text("\"\\x\\q\\101\\x1ff\\n\"\"\"a//c");
        text_q.push_back(8'd0);
        text_q.push_back(8'd0);
        add_text("#x");
        text_q.push_back(8'd0);
        add_text("\"ab\\");
        text_q.push_back(8'd0);
        text_q.push_back(8'hff);
        text_q.push_back(8'h80);
        text_q.push_back(8'd0);
        drain();

        sent = 0;
        foreach (limits[ph]) begin
            set_limit(limits[ph]);
            calm = (ph == 2);
            while (sent < (ph + 1) * 70) begin
                sent -= text_q.size();
                add_line();
                sent += text_q.size();
            end
            drain();
        end

        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
